[hdl/cbmur_pkg.sv]
`default_nettype none
// Shared sizes, codes, handshake structs and the RAM reset image.
// Used by cbmur_ctrl, cbmur_dp and the top level; no dependencies.
package cbmur_pkg;

  // RAM_WORDS and FIFO_DEPTH: powers of two
  localparam int RAM_WORDS        = 4096;
  localparam int FIFO_DEPTH       = 32;
  localparam int ROM_ADDRESS_BITS = 15;

  localparam int RAM_AW  = $clog2(RAM_WORDS);
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_SW = FIFO_AW + 1;

  localparam logic [14:0] ROM_MASK = 15'((32'd1 << ROM_ADDRESS_BITS) - 32'd1);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_MEM_RD = 3'd1;
  localparam logic [2:0] MODE_MEM_WR = 3'd2;
  localparam logic [2:0] MODE_IO_RD  = 3'd3;
  localparam logic [2:0] MODE_IO_WR  = 3'd4;
  localparam logic [2:0] MODE_SER_RX = 3'd5;

  localparam logic [7:0] PORT_STATUS = 8'h00;
  localparam logic [7:0] PORT_DATA   = 8'h01;

  localparam logic [7:0] STAT_RX_AVAIL = 8'h80;
  localparam logic [7:0] STAT_TX_BUSY  = 8'h40;
  localparam logic [7:0] RD_UNKNOWN    = 8'hAA;
  localparam logic [7:0] RD_EMPTY      = 8'hFF;
  localparam logic [7:0] ESCAPE_RESET  = 8'd7;

  localparam logic [7:0] BOOT_JP  = 8'hC3;
  localparam logic [7:0] BOOT_LO  = 8'h00;
  localparam logic [7:0] BOOT_HI  = 8'h80;

  typedef enum logic [1:0] {
    RD_FIX,
    RD_RAM,
    RD_FIFO
  } rd_sel_t;

  typedef struct packed {
    logic clear_wr;
    logic take;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctl_sts_t;

  function automatic logic [7:0] ram_init(input logic [RAM_AW-1:0] a);
    logic [7:0] v;
    v = 8'h00;
    if (a == RAM_AW'(0)) v = BOOT_JP;
    else if (a == RAM_AW'(1)) v = BOOT_LO;
    else if (a == RAM_AW'(2)) v = BOOT_HI;
    return v;
  endfunction

endpackage
`default_nettype wire

[hdl/cpu_bus_memory_and_uart_responder.sv]
`default_nettype none
// CPU bus / serial responder: an accepted beat goes through the pending registers into the output register.
// No new beat is accepted while one is in its access state, where the RAM/FIFO read is registered.
// The input stalls while a result waits in the output register; the next beat is
// accepted at the edge where that result leaves.
// After rst a clearing pass writes the RAM boot image to all 4096 words, one RAM word per
// cycle; no beat is accepted then, escape_code writes are. rst is synchronous, active high.
module cpu_bus_memory_and_uart_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  input  wire logic        tx_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             drive_valid,
  output logic             rom_select,
  output logic [14:0]      rom_address,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             overflow,
  output logic             escape_seen
);

  cbmur_pkg::ctl_cmd_t cmd;
  cbmur_pkg::ctl_sts_t sts;

  cbmur_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cbmur_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mode        (mode),
    .address     (address),
    .data        (data),
    .tx_ready    (tx_ready),
    .read_data   (read_data),
    .drive_valid (drive_valid),
    .rom_select  (rom_select),
    .rom_address (rom_address),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .overflow    (overflow),
    .escape_seen (escape_seen)
  );

`ifndef NO_ASSERTIONS
  a_rom_ram_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_valid && rom_select))
    else $error("ROM and RAM read in one beat");
  a_rx_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(overflow && escape_seen))
    else $error("overflow and escape in one beat");
  a_tx_not_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid |-> !drive_valid && !rom_select)
    else $error("transmit beat also drives bus");
`endif

endmodule
`default_nettype wire

[hdl/cbmur_ctrl.sv]
`default_nettype none
// Controller: clearing pass, beat acceptance and output register handshake.
// Depends on cbmur_pkg; drives the datapath through ctl_cmd_t.
module cbmur_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cbmur_pkg::ctl_cmd_t      cmd,
  input  wire cbmur_pkg::ctl_sts_t sts
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  state_t state;

  assign in_stall     = !(state == ST_IDLE && (!out_valid || !out_stall));
  assign cmd.take     = in_valid && !in_stall;
  assign cmd.clear_wr = (state == ST_CLEAR);
  assign cmd.commit   = (state == ST_ACCESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.clear_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (out_valid && !out_stall) out_valid <= 1'b0;
          if (cmd.take) state <= ST_ACCESS;
        end
        ST_ACCESS: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !cmd.take && !out_valid)
    else $error("beat accepted during clearing pass");
  a_commit_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.take))
    else $error("commit without accepted beat");
  a_out_free_on_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !out_valid)
    else $error("output register overwritten");
`endif

endmodule
`default_nettype wire

[hdl/cbmur_dp.sv]
`default_nettype none
// Datapath: RAM with reset sweep, receive FIFO, escape register, decode and output register.
// Depends on cbmur_pkg; controlled by cbmur_ctrl.
module cbmur_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cbmur_pkg::ctl_cmd_t cmd,
  output cbmur_pkg::ctl_sts_t      sts,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic [2:0]          mode,
  input  wire logic [15:0]         address,
  input  wire logic [7:0]          data,
  input  wire logic                tx_ready,
  output logic [7:0]               read_data,
  output logic                     drive_valid,
  output logic                     rom_select,
  output logic [14:0]              rom_address,
  output logic                     tx_valid,
  output logic [7:0]               tx_byte,
  output logic                     overflow,
  output logic                     escape_seen
);

  logic [7:0] ram [cbmur_pkg::RAM_WORDS];
  logic [7:0] fifo_mem [cbmur_pkg::FIFO_DEPTH];
  logic [7:0] ram_q;
  logic [7:0] fifo_q;

  logic [7:0]                     escape_code;
  logic [cbmur_pkg::RAM_AW-1:0]   clr_addr;
  logic [cbmur_pkg::FIFO_AW-1:0]  fifo_head;
  logic [cbmur_pkg::FIFO_CW-1:0]  fifo_count;

  cbmur_pkg::rd_sel_t pend_sel;
  logic [7:0]         pend_fix;
  logic               pend_dv, pend_rs, pend_tv, pend_ov, pend_es;
  logic [14:0]        pend_ra;
  logic [7:0]         pend_tb;

  cbmur_pkg::rd_sel_t sel_next;
  logic [7:0]         fix_next;
  logic               dv_next, rs_next, tv_next, ov_next, es_next;
  logic [14:0]        ra_next;
  logic [7:0]         tb_next;

  logic [7:0]                     port;
  logic [cbmur_pkg::RAM_AW-1:0]   ram_idx;
  logic                           fifo_empty, fifo_full;
  logic [cbmur_pkg::FIFO_SW-1:0]  tail_sum;
  logic [cbmur_pkg::FIFO_AW-1:0]  tail;
  logic [cbmur_pkg::FIFO_AW-1:0]  head_inc;
  logic                           do_pop, do_push;
  logic                           ram_we;
  logic [cbmur_pkg::RAM_AW-1:0]   ram_wa;
  logic [7:0]                     ram_wd;

  assign port       = address[7:0];
  assign ram_idx    = address[cbmur_pkg::RAM_AW-1:0];
  assign fifo_empty = (fifo_count == '0);
  assign fifo_full  = (fifo_count == cbmur_pkg::FIFO_CW'(cbmur_pkg::FIFO_DEPTH));
  assign tail_sum   = cbmur_pkg::FIFO_SW'(fifo_head) + cbmur_pkg::FIFO_SW'(fifo_count);
  assign tail       = (tail_sum >= cbmur_pkg::FIFO_SW'(cbmur_pkg::FIFO_DEPTH))
                    ? cbmur_pkg::FIFO_AW'(tail_sum - cbmur_pkg::FIFO_SW'(cbmur_pkg::FIFO_DEPTH))
                    : cbmur_pkg::FIFO_AW'(tail_sum);
  assign head_inc   = (fifo_head == cbmur_pkg::FIFO_AW'(cbmur_pkg::FIFO_DEPTH - 1))
                    ? '0 : fifo_head + 1'b1;

  assign do_pop  = cmd.take && mode == cbmur_pkg::MODE_IO_RD &&
                   port == cbmur_pkg::PORT_DATA && !fifo_empty;
  assign do_push = cmd.take && mode == cbmur_pkg::MODE_SER_RX &&
                   data != escape_code && !fifo_full;

  assign ram_we = cmd.clear_wr || (cmd.take && mode == cbmur_pkg::MODE_MEM_WR);
  assign ram_wa = cmd.clear_wr ? clr_addr : ram_idx;
  assign ram_wd = cmd.clear_wr ? cbmur_pkg::ram_init(clr_addr) : data;

  assign sts.clear_last = (clr_addr == cbmur_pkg::RAM_AW'(cbmur_pkg::RAM_WORDS - 1));

  always_comb begin
    sel_next = cbmur_pkg::RD_FIX;
    fix_next = 8'h00;
    dv_next  = 1'b0;
    rs_next  = 1'b0;
    ra_next  = 15'h0000;
    tv_next  = 1'b0;
    tb_next  = 8'h00;
    ov_next  = 1'b0;
    es_next  = 1'b0;
    unique case (mode)
      cbmur_pkg::MODE_MEM_RD: begin
        if (address[15]) begin
          rs_next = 1'b1;
          ra_next = address[14:0] & cbmur_pkg::ROM_MASK;
        end else begin
          sel_next = cbmur_pkg::RD_RAM;
          dv_next  = 1'b1;
        end
      end
      cbmur_pkg::MODE_IO_RD: begin
        dv_next = 1'b1;
        if (port == cbmur_pkg::PORT_STATUS) begin
          fix_next = (fifo_empty ? 8'h00 : cbmur_pkg::STAT_RX_AVAIL) |
                     (tx_ready ? 8'h00 : cbmur_pkg::STAT_TX_BUSY);
        end else if (port == cbmur_pkg::PORT_DATA) begin
          if (fifo_empty) fix_next = cbmur_pkg::RD_EMPTY;
          else sel_next = cbmur_pkg::RD_FIFO;
        end else begin
          fix_next = cbmur_pkg::RD_UNKNOWN;
        end
      end
      cbmur_pkg::MODE_IO_WR: begin
        if (port == cbmur_pkg::PORT_DATA) begin
          tv_next = 1'b1;
          tb_next = data;
        end
      end
      cbmur_pkg::MODE_SER_RX: begin
        if (data == escape_code) es_next = 1'b1;
        else if (fifo_full) ov_next = 1'b1;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_wa] <= ram_wd;
    ram_q <= ram[ram_idx];
    if (do_push) fifo_mem[tail] <= data;
    fifo_q <= fifo_mem[fifo_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code <= cbmur_pkg::ESCAPE_RESET;
      clr_addr    <= '0;
      fifo_head   <= '0;
      fifo_count  <= '0;
    end else begin
      if (cfg_we) escape_code <= cfg_wdata;
      if (cmd.clear_wr) clr_addr <= clr_addr + 1'b1;
      if (do_pop) begin
        fifo_head  <= head_inc;
        fifo_count <= fifo_count - 1'b1;
      end else if (do_push) begin
        fifo_count <= fifo_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_sel <= sel_next;
      pend_fix <= fix_next;
      pend_dv  <= dv_next;
      pend_rs  <= rs_next;
      pend_ra  <= ra_next;
      pend_tv  <= tv_next;
      pend_tb  <= tb_next;
      pend_ov  <= ov_next;
      pend_es  <= es_next;
    end
    if (cmd.commit) begin
      unique case (pend_sel)
        cbmur_pkg::RD_RAM:  read_data <= ram_q;
        cbmur_pkg::RD_FIFO: read_data <= fifo_q;
        default:            read_data <= pend_fix;
      endcase
      drive_valid <= pend_dv;
      rom_select  <= pend_rs;
      rom_address <= pend_ra;
      tx_valid    <= pend_tv;
      tx_byte     <= pend_tb;
      overflow    <= pend_ov;
      escape_seen <= pend_es;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= cbmur_pkg::FIFO_CW'(cbmur_pkg::FIFO_DEPTH))
    else $error("fifo count beyond depth");
  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    !(do_pop && do_push))
    else $error("pop and push in one beat");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push |=> fifo_count == $past(fifo_count) + 1'b1)
    else $error("push lost");
`endif

endmodule
`default_nettype wire

[dv/tb_cpu_bus_memory_and_uart_responder.sv]
// Self-checking bench for cpu_bus_memory_and_uart_responder: bus beats and serial bytes in,
// one predicted result per beat checked field by field against the block's output beats.
// Depends on cbmur_pkg and the RTL top level only.
module tb_cpu_bus_memory_and_uart_responder;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0]  rd;
    logic        dv;
    logic        rs;
    logic [14:0] ra;
    logic        tv;
    logic [7:0]  tb;
    logic        ov;
    logic        es;
  } bus_result_t;

  class responder_scoreboard;
    logic [7:0]                    ram [cbmur_pkg::RAM_WORDS];
    logic [7:0]                    rx_fifo [cbmur_pkg::FIFO_DEPTH];
    logic [cbmur_pkg::FIFO_AW-1:0] head;
    int                            fill;
    logic [7:0]                    escape;
    bus_result_t                   awaited [$];
    int                            errors;

    function new();
      for (int i = 0; i < cbmur_pkg::RAM_WORDS; i++) ram[i] = 8'h00;
      ram[0] = cbmur_pkg::BOOT_JP;
      ram[1] = cbmur_pkg::BOOT_LO;
      ram[2] = cbmur_pkg::BOOT_HI;
      head = '0;
      fill = 0;
      escape = cbmur_pkg::ESCAPE_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return awaited.size();
    endfunction

    function void note_beat(logic [2:0] m, logic [15:0] a, logic [7:0] d, logic tr);
      bus_result_t r;
      logic [7:0]  port;
      r = '0;
      port = a[7:0];
      case (m)
        cbmur_pkg::MODE_MEM_RD: begin
          if (a[15]) begin
            r.rs = 1'b1;
            r.ra = a[14:0] & cbmur_pkg::ROM_MASK;
          end else begin
            r.rd = ram[a[cbmur_pkg::RAM_AW-1:0]];
            r.dv = 1'b1;
          end
        end
        cbmur_pkg::MODE_MEM_WR: ram[a[cbmur_pkg::RAM_AW-1:0]] = d;
        cbmur_pkg::MODE_IO_RD: begin
          r.dv = 1'b1;
          if (port == cbmur_pkg::PORT_STATUS) begin
            r.rd = (fill != 0 ? cbmur_pkg::STAT_RX_AVAIL : 8'h00) |
                   (tr ? 8'h00 : cbmur_pkg::STAT_TX_BUSY);
          end else if (port == cbmur_pkg::PORT_DATA) begin
            if (fill == 0) begin
              r.rd = cbmur_pkg::RD_EMPTY;
            end else begin
              r.rd = rx_fifo[head];
              head = head + 1'b1;
              fill--;
            end
          end else begin
            r.rd = cbmur_pkg::RD_UNKNOWN;
          end
        end
        cbmur_pkg::MODE_IO_WR: begin
          if (port == cbmur_pkg::PORT_DATA) begin
            r.tv = 1'b1;
            r.tb = d;
          end
        end
        cbmur_pkg::MODE_SER_RX: begin
          if (d == escape) begin
            r.es = 1'b1;
          end else if (fill >= cbmur_pkg::FIFO_DEPTH) begin
            r.ov = 1'b1;
          end else begin
            rx_fifo[cbmur_pkg::FIFO_AW'(head + fill)] = d;
            fill++;
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    task cmp(string f, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", f, got, want));
    endtask

    task check_result(bus_result_t got);
      bus_result_t want;
      if (awaited.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = awaited.pop_front();
        cmp("read_data", got.rd, want.rd);
        cmp("drive_valid", got.dv, want.dv);
        cmp("rom_select", got.rs, want.rs);
        cmp("rom_address", got.ra, want.ra);
        cmp("tx_valid", got.tv, want.tv);
        cmp("tx_byte", got.tb, want.tb);
        cmp("overflow", got.ov, want.ov);
        cmp("escape_seen", got.es, want.es);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  mode = cbmur_pkg::MODE_IDLE;
  logic [15:0] address = 16'h0000;
  logic [7:0]  data = 8'h00;
  logic        tx_ready = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        drive_valid;
  logic        rom_select;
  logic [14:0] rom_address;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        overflow;
  logic        escape_seen;

  logic        quiet = 1'b0;
  logic [7:0]  esc_code = cbmur_pkg::ESCAPE_RESET;
  responder_scoreboard sb;

  cpu_bus_memory_and_uart_responder u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .address(address),
    .data(data), .tx_ready(tx_ready), .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .drive_valid(drive_valid), .rom_select(rom_select),
    .rom_address(rom_address), .tx_valid(tx_valid), .tx_byte(tx_byte),
    .overflow(overflow), .escape_seen(escape_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : result_side
    bus_result_t seen;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      seen = '{read_data, drive_valid, rom_select, rom_address,
               tx_valid, tx_byte, overflow, escape_seen};
      sb.check_result(seen);
    end
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  task automatic send_beat(logic [2:0] m, logic [15:0] a, logic [7:0] d, logic tr);
    while (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    data <= d;
    tx_ready <= tr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_beat(m, a, d, tr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_escape(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.escape = v;
    esc_code = v;
  endtask

  // fill past full, then pop past empty
  task automatic rx_burst();
    logic [7:0] d;
    for (int i = 0; i < cbmur_pkg::FIFO_DEPTH + 4; i++) begin
      d = 8'($urandom);
      if (d == esc_code) d = d ^ 8'h01;
      send_beat(cbmur_pkg::MODE_SER_RX, 16'($urandom), d, 1'($urandom));
    end
    for (int i = 0; i < cbmur_pkg::FIFO_DEPTH + 2; i++)
      send_beat(cbmur_pkg::MODE_IO_RD, {8'($urandom), cbmur_pkg::PORT_DATA}, 8'($urandom),
                1'($urandom));
  endtask

  task automatic random_beat();
    int          pick;
    logic [15:0] a;
    logic [7:0]  d;
    logic        tr;
    pick = $urandom_range(99);
    a = 16'($urandom);
    d = 8'($urandom);
    tr = 1'($urandom);
    if (pick < 24) begin
      send_beat(cbmur_pkg::MODE_MEM_WR, {4'($urandom), 7'd0, 5'($urandom)}, d, tr);
    end else if (pick < 44) begin
      if ($urandom_range(2) != 0) a = {1'b0, 3'($urandom), 7'd0, 5'($urandom)};
      send_beat(cbmur_pkg::MODE_MEM_RD, a, d, tr);
    end else if (pick < 64) begin
      if ($urandom_range(7) == 0) d = esc_code;
      send_beat(cbmur_pkg::MODE_SER_RX, a, d, tr);
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: a[7:0] = cbmur_pkg::PORT_STATUS;
        1, 2: a[7:0] = cbmur_pkg::PORT_DATA;
        default: ;
      endcase
      send_beat(cbmur_pkg::MODE_IO_RD, a, d, tr);
    end else if (pick < 92) begin
      if ($urandom_range(2) != 0) a[7:0] = cbmur_pkg::PORT_DATA;
      send_beat(cbmur_pkg::MODE_IO_WR, a, d, tr);
    end else begin
      case ($urandom_range(2))
        0: send_beat(cbmur_pkg::MODE_IDLE, a, d, tr);
        1: send_beat(MODE_SPARE_A, a, d, tr);
        default: send_beat(MODE_SPARE_B, a, d, tr);
      endcase
    end
  endtask

  initial begin
    #2000000;
    $display("cpu_bus_memory_and_uart_responder verification failed");
    $finish;
  end

  initial begin
    logic [7:0] phase_esc [4];
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h0000, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h0001, 8'hFF, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h7002, 8'h00, 1'b0);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h8000, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'hFFFF, 8'hFF, 1'b0);
    send_beat(cbmur_pkg::MODE_MEM_WR, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h0FFF, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_WR, 16'h1234, 8'h5A, 1'b1);
    send_beat(cbmur_pkg::MODE_MEM_RD, 16'h0234, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h0000, 8'h00, 1'b0);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'hFF01, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h00AA, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h00FF, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_WR, 16'h0001, 8'hA5, 1'b0);
    send_beat(cbmur_pkg::MODE_IO_WR, 16'h0102, 8'h3C, 1'b1);
    send_beat(cbmur_pkg::MODE_SER_RX, 16'h0000, cbmur_pkg::ESCAPE_RESET, 1'b1);
    send_beat(cbmur_pkg::MODE_SER_RX, 16'h0000, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_SER_RX, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h0100, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h0001, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h0001, 8'h00, 1'b0);
    send_beat(cbmur_pkg::MODE_IO_RD, 16'h0001, 8'h00, 1'b1);
    send_beat(cbmur_pkg::MODE_IDLE, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(MODE_SPARE_A, 16'h0001, 8'hFF, 1'b0);
    send_beat(MODE_SPARE_B, 16'hFFFF, 8'h07, 1'b1);
    drain();

    phase_esc[0] = 8'h00;
    phase_esc[1] = 8'hFF;
    phase_esc[2] = 8'($urandom_range(1, 254));
    phase_esc[3] = cbmur_pkg::ESCAPE_RESET;
    for (int p = 0; p < 4; p++) begin
      write_escape(phase_esc[p]);
      quiet = (p == 1);
      for (int n = 0; n < 60; n++) begin
        if (n == 20) rx_burst();
        random_beat();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0)
      $display("cpu_bus_memory_and_uart_responder verification clean");
    else
      $display("cpu_bus_memory_and_uart_responder verification failed");
    $finish;
  end
endmodule

[files.f]
hdl/cbmur_pkg.sv
hdl/cbmur_ctrl.sv
hdl/cbmur_dp.sv
hdl/cpu_bus_memory_and_uart_responder.sv
dv/tb_cpu_bus_memory_and_uart_responder.sv
